/* sv/elf_symbol_hash_table_builder_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the ELF symbol hash table builder
// Concurrent checks are sampled on clk and ignored while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ELF_SYMBOL_HASH_TABLE_BUILDER_MACROS_SVH
`define ELF_SYMBOL_HASH_TABLE_BUILDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ELFSH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ELFSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/elfsh_pkg.sv */
// ---------------------------------------------------------------------------
// elfsh_pkg
// Shared types, field widths and the ELF hash step for the hash table builder.
// ---------------------------------------------------------------------------
`default_nettype none

package elfsh_pkg;

  localparam int HASH_W       = 28;
  localparam int BYTE_W       = 8;
  localparam int SYM_W        = 10;
  localparam int CFG_W        = 7;
  localparam int BUCKET_OUT_W = 6;
  // Hash bits consumed per cycle by the modulo unit.
  localparam int STEP_BITS    = 4;

  localparam logic [31:0] HASH_TOP_MASK   = 32'hf000_0000;
  localparam int          HASH_FOLD_SHIFT = 24;

  typedef enum logic [1:0] {
    REQ_NAME_BYTE   = 2'd0,
    REQ_READ_BUCKET = 2'd1,
    REQ_READ_CHAIN  = 2'd2,
    REQ_IGNORED     = 2'd3
  } elfsh_req_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_READ   = 1'b1
  } elfsh_kind_t;

  typedef struct packed {
    elfsh_req_t          req_type;
    logic [BYTE_W-1:0]   name_byte;
    logic                last_byte;
    logic [SYM_W-1:0]    sym_index;
    logic [SYM_W-1:0]    read_index;
  } elfsh_in_t;

  typedef struct packed {
    elfsh_kind_t             result_kind;
    logic [HASH_W-1:0]       hash_word;
    logic [BUCKET_OUT_W-1:0] bucket_used;
    logic [SYM_W-1:0]        read_data;
  } elfsh_out_t;

  // One step of the System V ELF hash on a 28-bit running value.
  function automatic logic [HASH_W-1:0] elf_hash_step(input logic [HASH_W-1:0] h,
                                                      input logic [BYTE_W-1:0] b);
    logic [31:0] t;
    logic [31:0] g;
    t = {h, 4'b0000} + 32'(b);
    g = t & HASH_TOP_MASK;
    t = t ^ (g >> HASH_FOLD_SHIFT);
    t = t & ~g;
    return t[HASH_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/elf_symbol_hash_table_builder.sv */
// ---------------------------------------------------------------------------
// elf_symbol_hash_table_builder
// Builds an ELF System V symbol hash table in a bucket RAM and a chain RAM.
// ---------------------------------------------------------------------------
//
//   Channel   Dir   Handshake              Payload
//   in        in    start && !busy         in_item   (elfsh_in_t)
//   out       out   out_valid, one cycle   out_data  (elfsh_out_t)
//   cfg       in    cfg_we                 cfg_wdata (bucket count)
//
// A plain name byte or an ignored request is taken in idle; a read passes
// through the read state. A last name byte runs the modulo unit over the hash,
// STEP_BITS bits per step, then presents the remainder, reads the bucket head
// and walks the chain one word at a time. An index that cannot be inserted
// skips the head read. After reset, busy stays high while both RAMs are
// cleared over max(MAX_BUCKETS, MAX_SYMBOLS) addresses.
`default_nettype none

`include "elf_symbol_hash_table_builder_macros.svh"

module elf_symbol_hash_table_builder import elfsh_pkg::*; #(
  parameter int MAX_BUCKETS = 64,
  parameter int MAX_SYMBOLS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire elfsh_in_t        in_item,
  output logic                  out_valid,
  output elfsh_out_t            out_data,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int BA_W      = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;
  localparam int SA_W      = $clog2(MAX_SYMBOLS);
  localparam int NW        = $clog2(MAX_BUCKETS + 1);
  localparam int CLR_DEPTH = MAX_BUCKETS > MAX_SYMBOLS ? MAX_BUCKETS : MAX_SYMBOLS;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int STEP_W    = $clog2(MAX_SYMBOLS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_HEAD,
    ST_CHAIN,
    ST_READ
  } state_t;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  bucket_count_r;
  logic [HASH_W-1:0] running_hash_r, running_hash_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [NW-1:0]     bucket_r, bucket_nxt;
  logic [SYM_W-1:0]  node_r, node_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [CLR_W-1:0]  clr_r, clr_nxt;
  logic              rd_chain_r, rd_chain_nxt;
  logic              rd_oor_r, rd_oor_nxt;
  logic              out_valid_r, out_valid_nxt;
  elfsh_out_t        out_r, out_nxt;

  logic              accept;
  logic [HASH_W-1:0] hash_step;
  logic [NW-1:0]     n_eff;
  logic              mod_start;
  logic              mod_done;
  logic [NW-1:0]     mod_rem;

  logic              bucket_we;
  logic [BA_W-1:0]   bucket_waddr;
  logic [SYM_W-1:0]  bucket_wdata;
  logic [BA_W-1:0]   bucket_raddr;
  logic [SYM_W-1:0]  bucket_rdata;
  logic              chain_we;
  logic [SA_W-1:0]   chain_waddr;
  logic [SYM_W-1:0]  chain_wdata;
  logic [SA_W-1:0]   chain_raddr;
  logic [SYM_W-1:0]  chain_rdata;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign hash_step = elf_hash_step(running_hash_r, in_item.name_byte);

  // Zero counts as one bucket; counts above the table size saturate.
  always_comb begin
    if (bucket_count_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(bucket_count_r) > MAX_BUCKETS) begin
      n_eff = NW'(MAX_BUCKETS);
    end else begin
      n_eff = NW'(bucket_count_r);
    end
  end

  elfsh_mod #(
    .DIV_W (NW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (hash_nxt),
    .divisor  (n_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  elfsh_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_BUCKETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (bucket_we),
    .waddr (bucket_waddr),
    .wdata (bucket_wdata),
    .raddr (bucket_raddr),
    .rdata (bucket_rdata)
  );

  elfsh_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_chain_ram (
    .clk   (clk),
    .we    (chain_we),
    .waddr (chain_waddr),
    .wdata (chain_wdata),
    .raddr (chain_raddr),
    .rdata (chain_rdata)
  );

  always_comb begin
    state_nxt        = state_r;
    running_hash_nxt = running_hash_r;
    hash_nxt         = hash_r;
    sym_nxt          = sym_r;
    bucket_nxt       = bucket_r;
    node_nxt         = node_r;
    steps_nxt        = steps_r;
    clr_nxt          = clr_r;
    rd_chain_nxt     = rd_chain_r;
    rd_oor_nxt       = rd_oor_r;
    out_valid_nxt    = 1'b0;
    out_nxt          = out_r;
    mod_start        = 1'b0;

    bucket_we    = 1'b0;
    bucket_waddr = BA_W'(bucket_r);
    bucket_wdata = sym_r;
    bucket_raddr = BA_W'(in_item.read_index);
    chain_we     = 1'b0;
    chain_waddr  = SA_W'(node_r);
    chain_wdata  = sym_r;
    chain_raddr  = SA_W'(in_item.read_index);

    unique case (state_r)
      ST_CLEAR: begin
        bucket_we    = (32'(clr_r) < MAX_BUCKETS);
        bucket_waddr = clr_r[BA_W-1:0];
        bucket_wdata = '0;
        chain_we     = (32'(clr_r) < MAX_SYMBOLS);
        chain_waddr  = clr_r[SA_W-1:0];
        chain_wdata  = '0;
        clr_nxt      = clr_r + 1'b1;
        if (clr_r == CLR_W'(CLR_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.req_type)
            REQ_NAME_BYTE: begin
              if (in_item.last_byte) begin
                running_hash_nxt = '0;
                hash_nxt         = hash_step;
                sym_nxt          = in_item.sym_index;
                mod_start        = 1'b1;
                state_nxt        = ST_MOD;
              end else begin
                running_hash_nxt = hash_step;
              end
            end
            REQ_READ_BUCKET: begin
              rd_chain_nxt = 1'b0;
              rd_oor_nxt   = !(32'(in_item.read_index) < MAX_BUCKETS);
              state_nxt    = ST_READ;
            end
            REQ_READ_CHAIN: begin
              rd_chain_nxt = 1'b1;
              rd_oor_nxt   = !(32'(in_item.read_index) < MAX_SYMBOLS);
              state_nxt    = ST_READ;
            end
            REQ_IGNORED: begin
            end
            default: begin
            end
          endcase
        end
      end

      ST_MOD: begin
        bucket_raddr = BA_W'(mod_rem);
        if (mod_done) begin
          bucket_nxt = mod_rem;
          if (sym_r == '0 || 32'(sym_r) >= MAX_SYMBOLS) begin
            // Index not insertable: report the hash and bucket only.
            out_valid_nxt       = 1'b1;
            out_nxt.result_kind = KIND_INSERT;
            out_nxt.hash_word   = hash_r;
            out_nxt.bucket_used = BUCKET_OUT_W'(mod_rem);
            out_nxt.read_data   = '0;
            state_nxt           = ST_IDLE;
          end else begin
            state_nxt = ST_HEAD;
          end
        end
      end

      ST_HEAD: begin
        chain_raddr = SA_W'(bucket_rdata);
        node_nxt    = bucket_rdata;
        steps_nxt   = '0;
        state_nxt   = ST_CHAIN;
        if (bucket_rdata == '0) begin
          bucket_we = 1'b1;
          state_nxt = ST_IDLE;
        end else if (32'(bucket_rdata) >= MAX_SYMBOLS) begin
          state_nxt = ST_IDLE;
        end
        if (state_nxt == ST_IDLE) begin
          out_valid_nxt       = 1'b1;
          out_nxt.result_kind = KIND_INSERT;
          out_nxt.hash_word   = hash_r;
          out_nxt.bucket_used = BUCKET_OUT_W'(bucket_r);
          out_nxt.read_data   = '0;
        end
      end

      ST_CHAIN: begin
        chain_raddr = SA_W'(chain_rdata);
        node_nxt    = chain_rdata;
        steps_nxt   = steps_r + 1'b1;
        if (chain_rdata == '0) begin
          chain_we  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (steps_r == STEP_W'(MAX_SYMBOLS - 1)) begin
          // The walk found no tail within the table size: a cyclic chain.
          state_nxt = ST_IDLE;
        end else if (32'(chain_rdata) >= MAX_SYMBOLS) begin
          state_nxt = ST_IDLE;
        end
        if (state_nxt == ST_IDLE) begin
          out_valid_nxt       = 1'b1;
          out_nxt.result_kind = KIND_INSERT;
          out_nxt.hash_word   = hash_r;
          out_nxt.bucket_used = BUCKET_OUT_W'(bucket_r);
          out_nxt.read_data   = '0;
        end
      end

      ST_READ: begin
        out_valid_nxt       = 1'b1;
        out_nxt.result_kind = KIND_READ;
        out_nxt.hash_word   = '0;
        out_nxt.bucket_used = '0;
        if (rd_oor_r) begin
          out_nxt.read_data = '0;
        end else if (rd_chain_r) begin
          out_nxt.read_data = chain_rdata;
        end else begin
          out_nxt.read_data = bucket_rdata;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_r          <= '0;
      running_hash_r <= '0;
      bucket_count_r <= CFG_W'(1);
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_r          <= clr_nxt;
      running_hash_r <= running_hash_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        bucket_count_r <= cfg_wdata;
      end
    end
    hash_r     <= hash_nxt;
    sym_r      <= sym_nxt;
    bucket_r   <= bucket_nxt;
    node_r     <= node_nxt;
    steps_r    <= steps_nxt;
    rd_chain_r <= rd_chain_nxt;
    rd_oor_r   <= rd_oor_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ELFSH_ASSERT_NEXT(a_idle_no_result, state_r == ST_IDLE, !out_valid_r, "stray result")
  `ELFSH_ASSERT_SAME(a_head_empty, bucket_we && state_r == ST_HEAD, ~|bucket_rdata, "head in use")
  `ELFSH_ASSERT_SAME(a_tail_empty, chain_we && state_r == ST_CHAIN, ~|chain_rdata, "link in use")
  `ELFSH_ASSERT_SAME(a_bucket_in_range, mod_done, mod_rem < n_eff, "bucket out of range")

endmodule

`default_nettype wire

/* sv/elfsh_ram.sv */
// ---------------------------------------------------------------------------
// elfsh_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module elfsh_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/elfsh_mod.sv */
// ---------------------------------------------------------------------------
// elfsh_mod
// Iterative hash modulo unit: restoring remainder, STEP_BITS bits per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module elfsh_mod import elfsh_pkg::*; #(
  parameter int DIV_W = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [HASH_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]  divisor,
  output logic                   done,
  output logic      [DIV_W-1:0]  rem
);

  localparam int N_STEPS = HASH_W / STEP_BITS;
  localparam int CNT_W   = N_STEPS > 1 ? $clog2(N_STEPS) : 1;

  logic              run_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [HASH_W-1:0] div_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  d_r;
  logic [DIV_W-1:0]  rem_nxt;
  logic [DIV_W:0]    trial;

  // The partial remainder stays below the divisor, so one compare and
  // subtract per dividend bit is enough.
  always_comb begin
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {rem_nxt, div_r[HASH_W-1-i]};
      if (trial >= {1'b0, d_r}) begin
        trial = trial - {1'b0, d_r};
      end
      rem_nxt = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        div_r <= dividend;
        rem_r <= '0;
        d_r   <= divisor;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        div_r <= div_r << STEP_BITS;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(N_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

/* tb/elf_symbol_hash_table_builder_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// elf_symbol_hash_table_builder_tb
// Drives name bytes, bucket reads and chain reads into the hash table builder
// and checks every result against an in-bench prediction of the ELF hash,
// the bucket choice and the bucket and chain stores. The bucket count is
// changed between phases, including the out-of-range values.
// ---------------------------------------------------------------------------

module elf_symbol_hash_table_builder_tb;
  import elfsh_pkg::*;

  localparam int NUM_BUCKETS = 64;
  localparam int NUM_SYMBOLS = 1024;
  localparam int CYCLE_LIMIT = 5_000_000;

  class hash_table_board;
    logic [HASH_W-1:0] name_hash;
    logic [SYM_W-1:0]  heads [NUM_BUCKETS];
    logic [SYM_W-1:0]  links [NUM_SYMBOLS];
    logic [CFG_W-1:0]  bucket_count;
    elfsh_out_t        pending_results [$];
    int                errors;

    function new();
      name_hash = '0;
      foreach (heads[i]) heads[i] = '0;
      foreach (links[i]) links[i] = '0;
      bucket_count = 7'd1;
      errors = 0;
    endfunction

    function logic [HASH_W-1:0] elf_hash_byte(logic [HASH_W-1:0] h, logic [BYTE_W-1:0] b);
      logic [31:0] acc;
      logic [3:0]  top;
      acc = {h, 4'h0} + {24'h0, b};
      top = acc[31:28];
      // The nibble shifted out at the top is folded back in at bits 7:4.
      acc[7:4] = acc[7:4] ^ top;
      return acc[HASH_W-1:0];
    endfunction

    function int unsigned divisor();
      if (bucket_count == 0) return 1;
      if (bucket_count > NUM_BUCKETS) return NUM_BUCKETS;
      return int'(bucket_count);
    endfunction

    // Appends the symbol at the tail of the bucket's chain. A chain that
    // loops back on itself has no tail, so the symbol is dropped.
    function void link_symbol(logic [BUCKET_OUT_W-1:0] bucket, logic [SYM_W-1:0] sym);
      logic [SYM_W-1:0] node;
      if (sym == 0) return;
      if (heads[bucket] == 0) begin
        heads[bucket] = sym;
        return;
      end
      node = heads[bucket];
      for (int steps = 0; steps < NUM_SYMBOLS; steps++) begin
        if (links[node] == 0) begin
          links[node] = sym;
          return;
        end
        node = links[node];
      end
    endfunction

    function void note_transfer(elfsh_in_t it);
      elfsh_out_t  r;
      int unsigned bucket;
      r = '0;
      case (it.req_type)
        REQ_NAME_BYTE: begin
          name_hash = elf_hash_byte(name_hash, it.name_byte);
          if (it.last_byte) begin
            bucket = name_hash % divisor();
            link_symbol(bucket[BUCKET_OUT_W-1:0], it.sym_index);
            r.result_kind = KIND_INSERT;
            r.hash_word   = name_hash;
            r.bucket_used = bucket[BUCKET_OUT_W-1:0];
            pending_results = {pending_results, r};
            name_hash = '0;
          end
        end
        REQ_READ_BUCKET: begin
          r.result_kind = KIND_READ;
          if (it.read_index < NUM_BUCKETS) r.read_data = heads[it.read_index[5:0]];
          pending_results = {pending_results, r};
        end
        REQ_READ_CHAIN: begin
          r.result_kind = KIND_READ;
          r.read_data   = links[it.read_index];
          pending_results = {pending_results, r};
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t: mismatch: %s", $time, msg);
    endtask

    task check_result(elfsh_out_t got);
      elfsh_out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind)
        report_mismatch($sformatf("result_kind %0d, expected %0d",
                                  got.result_kind, want.result_kind));
      if (got.hash_word !== want.hash_word)
        report_mismatch($sformatf("hash_word %h, expected %h",
                                  got.hash_word, want.hash_word));
      if (got.bucket_used !== want.bucket_used)
        report_mismatch($sformatf("bucket_used %0d, expected %0d",
                                  got.bucket_used, want.bucket_used));
      if (got.read_data !== want.read_data)
        report_mismatch($sformatf("read_data %0d, expected %0d",
                                  got.read_data, want.read_data));
    endtask
  endclass

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  elfsh_in_t        in_item   = '0;
  logic             out_valid;
  elfsh_out_t       out_data;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  hash_table_board sb = new();
  int              cycles = 0;
  logic [SYM_W-1:0] next_symbol = 10'd1;

  elf_symbol_hash_table_builder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** elf_symbol_hash_table_builder: FAILED **");
      $finish;
    end
  end

  // Holds the item on the inputs until the block takes it. start is left
  // high so that a following item can go out on the very next cycle.
  task automatic send_item(elfsh_in_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_transfer(it);
  endtask

  // Mode 0 never idles; otherwise most gaps are short and a few are long.
  task automatic pause(int mode);
    int r;
    int n;
    n = 0;
    if (mode != 0) begin
      r = $urandom_range(99);
      if (r >= 92) n = $urandom_range(40, 8);
      else if (r >= 60) n = $urandom_range(3, 1);
    end
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic push(elfsh_in_t it, int mode);
    send_item(it);
    pause(mode);
  endtask

  // Waits for every outstanding result with start held low, then idles before returning.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_bucket_count(logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.bucket_count = value;
  endtask

  function automatic elfsh_in_t make_item(elfsh_req_t req, logic [BYTE_W-1:0] b,
                                          logic last, logic [SYM_W-1:0] sym,
                                          logic [SYM_W-1:0] ridx);
    elfsh_in_t it;
    it.req_type   = req;
    it.name_byte  = b;
    it.last_byte  = last;
    it.sym_index  = sym;
    it.read_index = ridx;
    return it;
  endfunction

  function automatic elfsh_in_t random_fields();
    elfsh_in_t it;
    it = elfsh_in_t'(31'($urandom));
    return it;
  endfunction

  // Mostly fresh indices; now and then a reused one, which can close a loop.
  function automatic logic [SYM_W-1:0] pick_symbol();
    int r;
    logic [SYM_W-1:0] sym;
    r = $urandom_range(99);
    if (r < 90) begin
      sym = next_symbol;
      next_symbol = (next_symbol == 10'd1023) ? 10'd1 : next_symbol + 10'd1;
    end else if (r < 95) begin
      sym = SYM_W'($urandom_range(1023, 1));
    end else if (r < 97) begin
      sym = '0;
    end else begin
      sym = 10'd1023;
    end
    return sym;
  endfunction

  function automatic elfsh_in_t random_read();
    elfsh_in_t it;
    it = random_fields();
    if ($urandom_range(1) == 0) begin
      it.req_type = REQ_READ_BUCKET;
      if ($urandom_range(99) < 85) it.read_index = SYM_W'($urandom_range(NUM_BUCKETS - 1));
    end else begin
      it.req_type = REQ_READ_CHAIN;
      if ($urandom_range(99) < 80) it.read_index = SYM_W'($urandom_range(next_symbol));
    end
    return it;
  endfunction

  task automatic run_phase(int n_items, int mode);
    int        count;
    int        r;
    int        len;
    elfsh_in_t it;
    count = 0;
    while (count < n_items) begin
      r = $urandom_range(99);
      if (r < 70) begin
        // A complete name, with reads slipped in between its bytes.
        len = $urandom_range(10, 1);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) begin
            push(random_read(), mode);
            count++;
          end
          it = random_fields();
          it.req_type  = REQ_NAME_BYTE;
          it.last_byte = (i == len - 1);
          if (it.last_byte) it.sym_index = pick_symbol();
          push(it, mode);
          count++;
        end
      end else if (r < 88) begin
        push(random_read(), mode);
        count++;
      end else if (r < 94) begin
        it = random_fields();
        it.req_type = REQ_IGNORED;
        push(it, mode);
      end else begin
        // A name cut short: its bytes carry over into the next name's hash.
        len = $urandom_range(3, 1);
        for (int i = 0; i < len; i++) begin
          it = random_fields();
          it.req_type  = REQ_NAME_BYTE;
          it.last_byte = 1'b0;
          push(it, mode);
          count++;
        end
      end
      if ($urandom_range(49) == 0) drain();
    end
  endtask

  initial begin
    logic [CFG_W-1:0] settings [8];
    settings = '{7'd1, 7'd0, 7'd127, 7'd7, 7'd33, 7'd64,
                 CFG_W'($urandom_range(64, 1)), CFG_W'($urandom_range(127))};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // The block clears both stores after reset and reports busy meanwhile.
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed part: with 64 buckets a one-byte name 0x3f lands in the last
    // bucket. Inserting the same index twice makes its chain loop, so the
    // next insertion there finds no tail and is dropped.
    write_bucket_count(7'd64);
    push(make_item(REQ_NAME_BYTE, 8'h3f, 1'b1, 10'd1, 10'd0), 1);
    push(make_item(REQ_NAME_BYTE, 8'h3f, 1'b1, 10'd1023, 10'd1023), 1);
    push(make_item(REQ_NAME_BYTE, 8'h3f, 1'b1, 10'd1023, 10'd0), 1);
    push(make_item(REQ_NAME_BYTE, 8'h3f, 1'b1, 10'd2, 10'd0), 1);
    // Eight 0xff bytes push bits into the top nibble and exercise the fold.
    for (int i = 0; i < 8; i++)
      push(make_item(REQ_NAME_BYTE, 8'hff, i == 7, 10'd5, 10'd0), 0);
    push(make_item(REQ_NAME_BYTE, 8'h00, 1'b1, 10'd0, 10'd0), 1);
    push(make_item(REQ_READ_BUCKET, 8'h00, 1'b0, 10'd0, 10'd63), 1);
    push(make_item(REQ_READ_BUCKET, 8'h00, 1'b0, 10'd0, 10'd64), 1);
    push(make_item(REQ_READ_BUCKET, 8'hff, 1'b1, 10'd1023, 10'd1023), 1);
    push(make_item(REQ_READ_BUCKET, 8'h00, 1'b0, 10'd0, 10'd0), 1);
    push(make_item(REQ_READ_CHAIN, 8'h00, 1'b0, 10'd0, 10'd1), 1);
    push(make_item(REQ_READ_CHAIN, 8'h00, 1'b0, 10'd0, 10'd1023), 1);
    push(make_item(REQ_READ_CHAIN, 8'h00, 1'b0, 10'd0, 10'd0), 1);
    push(make_item(REQ_IGNORED, 8'hff, 1'b1, 10'd1023, 10'd1023), 1);
    next_symbol = 10'd6;
    drain();

    foreach (settings[p]) begin
      write_bucket_count(settings[p]);
      run_phase(95, (p % 3 == 2) ? 0 : 1);
      drain();
    end

    repeat (64) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** elf_symbol_hash_table_builder: PASSED **");
    end else begin
      $display("** elf_symbol_hash_table_builder: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/elfsh_pkg.sv
sv/elfsh_ram.sv
sv/elfsh_mod.sv
sv/elf_symbol_hash_table_builder.sv
tb/elf_symbol_hash_table_builder_tb.sv
